// ===== sv/residue_vector_classifier_core_defines.svh =====
// Assertion macros for the residue vector classifier checker.
// Depends on nothing; taken in by the checker file.
`ifndef RESIDUE_VECTOR_CLASSIFIER_CORE_DEFINES_SVH
`define RESIDUE_VECTOR_CLASSIFIER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RVC_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rvc check failed");

// antecedent implies consequent in the next cycle
`define RVC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rvc check failed");

`endif

// ===== sv/rvc_pkg.sv =====
// Shared constants, types and helpers of the residue vector classifier.
// No dependencies.
package rvc_pkg;

   localparam int MAX_RANK      = 16;
   localparam int MAX_CLASSES   = 64;
   localparam int CONTENT_WIDTH = 8;

   localparam int RES_W     = 7;                            // residue / modulus width
   localparam int REM_W     = RES_W + 1;                    // partial remainder
   localparam int LEN_W     = 5;                            // vector_length register
   localparam int POS_W     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int CLS_W     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CNT_W     = $clog2(MAX_CLASSES + 1);
   localparam int STEP_W    = (CONTENT_WIDTH > 1) ? $clog2(CONTENT_WIDTH) : 1;
   localparam int VIDX_W    = 16;
   localparam int OUT_CLS_W = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VLEN    = 1'd1;

   localparam logic [RES_W-1:0] MODULUS_RESET = 7'd2;
   localparam logic [LEN_W-1:0] VLEN_RESET    = 5'd16;

   // controller to datapath
   typedef struct packed {
      logic load;     // item taken, start reduction
      logic step;     // one restoring division step
      logic fix;      // sign correction, issue row read
      logic cmp;      // compare row, write column
      logic search;   // first match over classes
      logic emit;     // load result, update store
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
      logic vec_end;
      logic rsp_free;
   } dp_stat_type;

   // effective vector length: 0 acts as 1, values above MAX_RANK clamp
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      if (v == '0) r = LEN_W'(1);
      else if (v > LEN_W'(MAX_RANK)) r = LEN_W'(MAX_RANK);
      else r = v;
      return r;
   endfunction

endpackage

// ===== sv/rvc_channels.sv =====
// Handshake channels of the residue vector classifier.
// Depends on rvc_pkg.
interface rvc_req_if import rvc_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic signed [CONTENT_WIDTH-1:0] content_value;
   logic                            new_set;
   modport source (output valid, content_value, new_set, input ready);
   modport sink (input valid, content_value, new_set, output ready);
endinterface

interface rvc_rsp_if import rvc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VIDX_W-1:0]    vector_index;
   logic [OUT_CLS_W-1:0] class_index;
   logic                 new_class;
   logic                 table_full;
   modport source (output valid, vector_index, class_index, new_class, table_full,
                   input ready);
   modport sink (input valid, vector_index, class_index, new_class, table_full,
                 output ready);
endinterface

// ===== sv/rvc_ctrl.sv =====
// Sequencer of the residue vector classifier: one item at a time.
// Depends on rvc_pkg.
module rvc_ctrl import rvc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_FIX  = 6'b000100,
      ST_CMP  = 6'b001000,
      ST_SRCH = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // commands
   always_comb begin
      cmd        = '0;
      cmd.load   = req_ready && req_valid;
      cmd.step   = (state_ff == ST_DIV);
      cmd.fix    = (state_ff == ST_FIX);
      cmd.cmp    = (state_ff == ST_CMP);
      cmd.search = (state_ff == ST_SRCH);
      cmd.emit   = (state_ff == ST_EMIT) && stat.rsp_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DIV;
         ST_DIV:  if (stat.div_last) state_in = ST_FIX;
         ST_FIX:  state_in = ST_CMP;
         ST_CMP:  state_in = stat.vec_end ? ST_SRCH : ST_IDLE;
         ST_SRCH: state_in = ST_EMIT;
         ST_EMIT: if (stat.rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== sv/rvc_datapath.sv =====
// Datapath: config registers, serial modulo, class store, match search, result reg.
// Depends on rvc_pkg.
module rvc_datapath import rvc_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [CSR_IDX_W-1:0]            csr_index,
   input  logic [CSR_DAT_W-1:0]            csr_write_data,
   input  logic signed [CONTENT_WIDTH-1:0] in_value,
   input  logic                            in_new_set,
   input  ctrl_cmd_type                    cmd,
   output dp_stat_type                     stat,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [VIDX_W-1:0]               rsp_vector_index,
   output logic [OUT_CLS_W-1:0]            rsp_class_index,
   output logic                            rsp_new_class,
   output logic                            rsp_table_full
);

   // configuration
   logic [RES_W-1:0] modulus_ff;
   logic [LEN_W-1:0] vlen_ff;
   logic [RES_W-1:0] mod_eff;
   logic [LEN_W-1:0] len_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         vlen_ff    <= VLEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_write_data[RES_W-1:0];
            CSR_VLEN:    vlen_ff    <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign mod_eff = (modulus_ff == '0) ? RES_W'(1) : modulus_ff;
   assign len_eff = clamp_len(vlen_ff);

   // restoring division of the magnitude, one bit per cycle
   logic [CONTENT_WIDTH-1:0] dvd_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     neg_ff;
   logic [REM_W-1:0]         rem_shift;
   logic [RES_W-1:0]         residue_ff;
   logic [RES_W-1:0]         rem_low;

   assign rem_shift = {rem_ff[RES_W-1:0], dvd_ff[CONTENT_WIDTH-1]};
   assign rem_low   = rem_ff[RES_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= in_value[CONTENT_WIDTH-1];
         dvd_ff  <= in_value[CONTENT_WIDTH-1] ? CONTENT_WIDTH'(-in_value)
                                              : CONTENT_WIDTH'(in_value);
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.step) begin
         dvd_ff  <= {dvd_ff[CONTENT_WIDTH-2:0], 1'b0};
         rem_ff  <= (rem_shift >= {1'b0, mod_eff}) ? rem_shift - {1'b0, mod_eff}
                                                   : rem_shift;
         step_ff <= step_ff + STEP_W'(1);
      end
      // negative values wrap upward
      if (cmd.fix) begin
         residue_ff <= (neg_ff && rem_low != '0) ? mod_eff - rem_low : rem_low;
      end
   end

   assign stat.div_last = (step_ff == STEP_W'(CONTENT_WIDTH - 1));

   // vector position, class count, vector numbering, match bits
   logic [POS_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [VIDX_W-1:0]      vcnt_ff;
   logic [MAX_CLASSES-1:0] match_ff;
   logic [POS_W-1:0]       clen_ff [MAX_CLASSES];   // last stored position per class
   logic                   room;

   assign room          = (count_ff < CNT_W'(MAX_CLASSES));
   assign stat.vec_end  = ({1'b0, pos_ff} + (POS_W + 1)'(1)) >= (POS_W + 1)'(len_eff);

   // class store: one row per position, one column per class
   logic [RES_W-1:0] store_mem [MAX_RANK][MAX_CLASSES];
   logic [RES_W-1:0] row_ff [MAX_CLASSES];

   always_ff @(posedge clock) begin
      if (cmd.fix) row_ff <= store_mem[pos_ff];
      // candidate column gets this residue; kept only if the vector opens a class
      if (cmd.cmp && room) store_mem[pos_ff][count_ff[CLS_W-1:0]] <= residue_ff;
   end

   // per-class compare against the row
   logic [MAX_CLASSES-1:0] eq_vec;
   always_comb begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
         eq_vec[c] = ((pos_ff <= clen_ff[c]) ? row_ff[c] : '0) == residue_ff;
      end
   end

   // first matching class
   logic [CLS_W-1:0] found_ff;
   logic             hit_ff;
   logic [CLS_W-1:0] found_c;
   logic             hit_c;
   always_comb begin
      found_c = '0;
      hit_c   = 1'b0;
      for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
         if (match_ff[c] && (CNT_W'(c) < count_ff)) begin
            found_c = CLS_W'(c);
            hit_c   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         found_ff <= found_c;
         hit_ff   <= hit_c;
      end
   end

   // store bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         vcnt_ff  <= '0;
         match_ff <= '1;
      end else if (cmd.load && in_new_set) begin
         pos_ff   <= '0;
         count_ff <= '0;
         vcnt_ff  <= '0;
         match_ff <= '1;
      end else if (cmd.cmp) begin
         match_ff <= match_ff & eq_vec;
         if (!stat.vec_end) pos_ff <= pos_ff + POS_W'(1);
      end else if (cmd.emit) begin
         pos_ff   <= '0;
         match_ff <= '1;
         vcnt_ff  <= vcnt_ff + VIDX_W'(1);
         if (!hit_ff && room) count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit && !hit_ff && room) clen_ff[count_ff[CLS_W-1:0]] <= pos_ff;
   end

   // result register
   logic                 rsp_valid_ff;
   logic [VIDX_W-1:0]    vidx_ff;
   logic [OUT_CLS_W-1:0] cls_ff;
   logic                 newc_ff;
   logic                 full_ff;

   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         vidx_ff <= vcnt_ff;
         if (hit_ff) begin
            cls_ff  <= OUT_CLS_W'(found_ff);
            newc_ff <= 1'b0;
            full_ff <= 1'b0;
         end else if (room) begin
            cls_ff  <= count_ff[OUT_CLS_W-1:0];
            newc_ff <= 1'b1;
            full_ff <= 1'b0;
         end else begin
            cls_ff  <= '0;
            newc_ff <= 1'b0;
            full_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vector_index = vidx_ff;
   assign rsp_class_index  = cls_ff;
   assign rsp_new_class    = newc_ff;
   assign rsp_table_full   = full_ff;

endmodule

// ===== sv/residue_vector_classifier_core.sv =====
// Top level of the residue vector classifier: sequencer plus datapath.
// Depends on rvc_pkg, rvc_channels, rvc_ctrl, rvc_datapath.
//
//   channel   direction  carries
//   req_chan  in         content_value, new_set
//   rsp_chan  out        vector_index, class_index, new_class, table_full
//   csr_*     in         modulus (index 0), vector_length (index 1)
//
// An item is accepted, passes the serial modulo divider bit by bit, then gets its
// sign fix and store row read, and then its compare.
// The last item of a vector adds a search and an emit step.
// A result waits in the output register; the next item is taken meanwhile, and
// the block stalls in emit only if a second result finds that register full.
// Reset is synchronous; the class store needs no clearing pass.
module residue_vector_classifier_core import rvc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rvc_req_if.sink              req_chan,
   rvc_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_write_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         ready;

   assign req_chan.ready = ready;

   rvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rvc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_value         (req_chan.content_value),
      .in_new_set       (req_chan.new_set),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_vector_index (rsp_chan.vector_index),
      .rsp_class_index  (rsp_chan.class_index),
      .rsp_new_class    (rsp_chan.new_class),
      .rsp_table_full   (rsp_chan.table_full)
   );

endmodule

// ===== sv/rvc_checker.sv =====
// Port-level checks of the residue vector classifier, bound to the top level.
// Depends on rvc_pkg and residue_vector_classifier_core_defines.svh.
`include "residue_vector_classifier_core_defines.svh"

module rvc_checker import rvc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VIDX_W-1:0]    rsp_vector_index,
   input logic [OUT_CLS_W-1:0] rsp_class_index,
   input logic                 rsp_new_class,
   input logic                 rsp_table_full
);

   // a stalled result stays offered
   `RVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // and keeps its index
   `RVC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_vector_index))
   // a full table never reports a new class, and reports class zero
   `RVC_ASSERT_NOW(a_full_flags, clock, reset, rsp_valid && rsp_table_full, !rsp_new_class && rsp_class_index == '0)
   // one item at a time: busy right after taking one
   `RVC_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind residue_vector_classifier_core rvc_checker u_rvc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_vector_index (rsp_chan.vector_index),
   .rsp_class_index  (rsp_chan.class_index),
   .rsp_new_class    (rsp_chan.new_class),
   .rsp_table_full   (rsp_chan.table_full)
);

// ===== test/residue_vector_classifier_core_test.sv =====
// Self-checking test of the residue vector classifier core: random and directed
// items against a behavioral class-table predictor. Depends on rvc_pkg, rvc_channels.
module residue_vector_classifier_core_test;
   import rvc_pkg::*;

   localparam int IDLE_MAX   = 18;
   localparam int DRAIN_WAIT = 40;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [VIDX_W-1:0]    vector_index;
      logic [OUT_CLS_W-1:0] class_index;
      logic                 new_class;
      logic                 table_full;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MODULUS;
   logic [CSR_DAT_W-1:0] csr_write_data = '0;

   rvc_req_if req_chan();
   rvc_rsp_if rsp_chan();

   residue_vector_classifier_core DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state
   logic [RES_W-1:0] class_rows [MAX_CLASSES][MAX_RANK];
   logic [RES_W-1:0] pending_row [MAX_RANK];
   logic             still_match [MAX_CLASSES];
   int               known_classes;
   int               slot;
   logic [VIDX_W-1:0] vector_count;
   logic [RES_W-1:0] modulus_reg;
   logic [LEN_W-1:0] length_reg;

   verdict_type verdicts_due[$];
   int  errors;
   int  items_sent;
   int  results_seen;
   int  full_seen;
   int  quiet_cycles;
   bit  idle_enabled;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.content_value = '0;
      req_chan.new_set = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   // clear match flags for a fresh vector
   task automatic restart_vector();
      slot = 0;
      for (int c = 0; c < MAX_CLASSES; c++) still_match[c] = 1'b1;
   endtask

   // residue classification of one item; queues a verdict at vector end
   task automatic classify_item(input logic signed [CONTENT_WIDTH-1:0] value,
                                input logic fresh_set);
      int len;
      int m;
      int r;
      int hit;
      verdict_type v;
      len = clamp_len(length_reg);
      m = (modulus_reg == 0) ? 1 : modulus_reg;
      hit = -1;
      if (fresh_set) begin
         known_classes = 0;
         vector_count = '0;
         restart_vector();
      end
      r = int'(value) % m;
      if (r < 0) r += m;
      pending_row[slot] = RES_W'(r);
      for (int c = 0; c < known_classes; c++)
         if (class_rows[c][slot] != RES_W'(r)) still_match[c] = 1'b0;
      if (slot + 1 < len) begin
         slot++;
         return;
      end
      for (int c = 0; c < known_classes; c++)
         if (still_match[c] && hit < 0) hit = c;
      v.vector_index = vector_count;
      if (hit >= 0) begin
         v.class_index = OUT_CLS_W'(hit);
         v.new_class = 1'b0;
         v.table_full = 1'b0;
      end else if (known_classes < MAX_CLASSES) begin
         for (int k = 0; k < MAX_RANK; k++)
            class_rows[known_classes][k] = (k <= slot) ? pending_row[k] : '0;
         v.class_index = OUT_CLS_W'(known_classes);
         v.new_class = 1'b1;
         v.table_full = 1'b0;
         known_classes++;
      end else begin
         v.class_index = '0;
         v.new_class = 1'b0;
         v.table_full = 1'b1;
      end
      verdicts_due = {verdicts_due, v};
      vector_count++;
      restart_vector();
   endtask

   // send one item, predicting its effect when accepted; valid drops only
   // when an idle gap follows or when sending stops
   task automatic send_item(input logic signed [CONTENT_WIDTH-1:0] value,
                            input logic fresh_set);
      int gap;
      gap = idle_enabled ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.content_value <= value;
      req_chan.new_set <= fresh_set;
      do @(posedge clock); while (!req_chan.ready);
      classify_item(value, fresh_set);
      items_sent++;
   endtask

   // wait for all verdicts, then let the pipeline settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MODULUS) modulus_reg = data;
      else length_reg = LEN_W'(data);
   endtask

   // result checker with random receiver stalls
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_enabled ? $urandom_range(0, IDLE_MAX) : 0;
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         results_seen++;
         if (rsp_chan.table_full) full_seen++;
         if (verdicts_due.size() == 0) begin
            $display("%0t: result with none expected: %h", $time,
                     {rsp_chan.vector_index, rsp_chan.class_index,
                      rsp_chan.new_class, rsp_chan.table_full});
            errors++;
         end else begin
            verdict_type e;
            e = verdicts_due.pop_front();
            if (rsp_chan.vector_index !== e.vector_index) begin
               $display("%0t: vector_index expected %0d actual %0d", $time,
                        e.vector_index, rsp_chan.vector_index);
               errors++;
            end
            if (rsp_chan.class_index !== e.class_index) begin
               $display("%0t: class_index expected %0d actual %0d", $time,
                        e.class_index, rsp_chan.class_index);
               errors++;
            end
            if (rsp_chan.new_class !== e.new_class) begin
               $display("%0t: new_class expected %0d actual %0d", $time,
                        e.new_class, rsp_chan.new_class);
               errors++;
            end
            if (rsp_chan.table_full !== e.table_full) begin
               $display("%0t: table_full expected %0d actual %0d", $time,
                        e.table_full, rsp_chan.table_full);
               errors++;
            end
         end
      end
   end

   // watchdog over cycles with no handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // extremes of the content range, both signs, mod 1/127
   task automatic test_value_extremes();
      write_register(CSR_MODULUS, 7'd127);
      write_register(CSR_VLEN, 5'd4);
      send_item(-8'sd128, 1'b1);
      send_item(8'sd127, 1'b0);
      send_item(-8'sd1, 1'b0);
      send_item(8'sd0, 1'b0);
      send_item(-8'sd128, 1'b0);
      send_item(8'sd127, 1'b0);
      send_item(-8'sd1, 1'b0);
      send_item(8'sd0, 1'b0);
      write_register(CSR_MODULUS, 7'd0);   // zero acts as one
      send_item(8'sd55, 1'b0);
      send_item(-8'sd77, 1'b0);
      send_item(8'sd1, 1'b0);
      send_item(8'sd2, 1'b0);
   endtask

   // length zero, above the rank limit, and lowered mid-vector
   task automatic test_length_edges();
      write_register(CSR_MODULUS, 7'd1);
      write_register(CSR_VLEN, 5'd0);
      send_item(8'sd3, 1'b1);
      send_item(8'sd4, 1'b0);
      write_register(CSR_MODULUS, 7'd5);
      write_register(CSR_VLEN, 5'd31);
      for (int i = 0; i < 17; i++) send_item(8'(i * 7 - 50), 1'b0);
      drain();
      write_register(CSR_VLEN, 5'd16);
      for (int i = 0; i < 7; i++) send_item(8'(i), 1'b0);
      write_register(CSR_VLEN, 5'd3);   // position already past new length
      send_item(8'sd9, 1'b0);
      // new set while a vector is partly collected
      send_item(8'sd1, 1'b0);
      send_item(8'sd2, 1'b1);
   endtask

   // more distinct vectors than table entries
   task automatic test_table_full();
      write_register(CSR_MODULUS, 7'd127);
      write_register(CSR_VLEN, 5'd1);
      for (int i = 0; i < MAX_CLASSES + 6; i++) send_item(8'(i), i == 0);
      send_item(8'sd5, 1'b0);
   endtask

   // random content with varied configuration and occasional new sets
   task automatic test_random_vectors();
      int m;
      int len;
      for (int phase = 0; phase < 12; phase++) begin
         idle_enabled = (phase % 4) != 3;
         m = (phase == 0) ? 127 : (phase == 1) ? 1 : $urandom_range(0, 127);
         len = (phase == 2) ? 16 : $urandom_range(0, 20);
         write_register(CSR_MODULUS, 7'(m));
         write_register(CSR_VLEN, 5'(len));
         for (int i = 0; i < 122; i++)
            send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 60) == 0));
      end
      idle_enabled = 1'b1;
   endtask

   // long set to wrap vector numbering is too slow; check index growth instead
   task automatic test_index_run();
      write_register(CSR_MODULUS, 7'd2);
      write_register(CSR_VLEN, 5'd1);
      for (int i = 0; i < 80; i++) send_item(8'($urandom_range(0, 255)), i == 0);
   endtask

   initial begin
      errors = 0; items_sent = 0; results_seen = 0; full_seen = 0;
      quiet_cycles = 0; idle_enabled = 1'b1;
      modulus_reg = MODULUS_RESET; length_reg = VLEN_RESET;
      known_classes = 0; vector_count = '0;
      restart_vector();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_value_extremes();
      test_length_edges();
      test_table_full();
      test_random_vectors();
      test_index_run();
      drain();
      $display("Sent %0d items, checked %0d results (%0d with table full).",
               items_sent, results_seen, full_seen);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+sv
sv/rvc_pkg.sv
sv/rvc_channels.sv
sv/rvc_ctrl.sv
sv/rvc_datapath.sv
sv/residue_vector_classifier_core.sv
sv/rvc_checker.sv
test/residue_vector_classifier_core_test.sv
